FILE: rtl/sprite_entry_chain_expander_assert.svh
// assertion macros for the sprite entry chain expander checker
// no dependencies; included by the checker file
`ifndef SPRITE_ENTRY_CHAIN_EXPANDER_ASSERT_SVH
`define SPRITE_ENTRY_CHAIN_EXPANDER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define SECE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sece assertion failed");

// next-cycle implication, quiet while reset is held
`define SECE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sece assertion failed");

// next-cycle implication that also runs through reset
`define SECE_ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sece reset assertion failed");

`endif

FILE: rtl/sece_pkg.sv
// shared types and constants of the sprite entry chain expander
// no dependencies; used by the config interface, the controller, the datapath and the top level
package sece_pkg;

    // config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPRITE_X_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_FLIPPED  = 2'd1;

    // attribute byte bits
    localparam int ATTR_ENABLE = 0;
    localparam int ATTR_Y_MSB  = 1;
    localparam int ATTR_X_MSB  = 2;
    localparam int ATTR_FLIP_Y = 3;
    localparam int ATTR_FLIP_X = 4;
    localparam int ATTR_CHAIN_LSB = 5;
    localparam int CHAIN_W = 3;

    // position arithmetic, 11-bit wrapping
    localparam int POS_W = 11;
    localparam int SX_W  = 10;
    localparam logic [POS_W-1:0] X_WRAP_LIMIT = 11'd496;
    localparam logic [POS_W-1:0] POS_WRAP     = 11'd512;
    localparam logic [8:0]       Y_BASE       = 9'd256;
    localparam logic [POS_W-1:0] TILE_STEP    = 11'd16;
    localparam logic [POS_W-1:0] FLIP_Y_BASE  = 11'd240;
    localparam logic [POS_W-1:0] FLIP_X_BASE  = 11'd304;

    // one sprite attribute entry
    typedef struct packed {
        logic [7:0] y_low_byte;
        logic [7:0] attribute_byte;
        logic [7:0] code_low_byte;
        logic [7:0] code_high_byte;
        logic [3:0] colour_bank_in;
        logic [7:0] x_low_byte;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    // handshake and datapath status into the controller
    typedef struct packed {
        logic in_valid;
        logic entry_enabled;
        logic out_ready;
        logic last;
    } t_ctrl_status;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/sece_in_if.sv
// input channel carrying one sprite attribute entry
// depends on nothing but the field widths
interface sece_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] y_low_byte;
    logic [7:0] attribute_byte;
    logic [7:0] code_low_byte;
    logic [7:0] code_high_byte;
    logic [3:0] colour_bank_in;
    logic [7:0] x_low_byte;

    modport source (output valid, y_low_byte, attribute_byte, code_low_byte,
                    code_high_byte, colour_bank_in, x_low_byte, input ready);
    modport sink   (input valid, y_low_byte, attribute_byte, code_low_byte,
                    code_high_byte, colour_bank_in, x_low_byte, output ready);
    modport mon    (input valid, ready, y_low_byte, attribute_byte, code_low_byte,
                    code_high_byte, colour_bank_in, x_low_byte);
endinterface

FILE: rtl/sece_out_if.sv
// output channel carrying one tile draw command
// depends on nothing but the field widths
interface sece_out_if;
    logic              valid;
    logic              ready;
    logic [15:0]       tile_code;
    logic [3:0]        colour_bank_out;
    logic              flip_x_out;
    logic              flip_y_out;
    logic signed [9:0] screen_x;
    logic signed [10:0] screen_y;
    logic              last_of_chain;

    modport source (output valid, tile_code, colour_bank_out, flip_x_out, flip_y_out,
                    screen_x, screen_y, last_of_chain, input ready);
    modport sink   (input valid, tile_code, colour_bank_out, flip_x_out, flip_y_out,
                    screen_x, screen_y, last_of_chain, output ready);
    modport mon    (input valid, ready, tile_code, colour_bank_out, flip_x_out,
                    flip_y_out, screen_x, screen_y, last_of_chain);
endinterface

FILE: rtl/sece_cfg_if.sv
// configuration write channel: register index and write data
// depends on sece_pkg for the widths
interface sece_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sece_pkg::CFG_INDEX_W-1:0] index;
    logic [sece_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
    modport mon    (input valid, ready, index, data);
endinterface

FILE: rtl/sece_ctrl.sv
// controller of the sprite entry chain expander: accept, emit, return
// depends on sece_pkg for the state and command types
module sece_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sece_pkg::t_ctrl_status i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output sece_pkg::t_dp_cmd      o_cmd
);

    sece_pkg::t_state r_state, n_state;
    logic             w_take_entry;
    logic             w_chain_done;

    // a new entry may come in while idle or as the last command leaves
    assign w_chain_done = (r_state == sece_pkg::ST_EMIT) && i_status.out_ready
                          && i_status.last;
    assign w_take_entry = i_status.in_valid && i_status.entry_enabled
                          && ((r_state == sece_pkg::ST_IDLE) || w_chain_done);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sece_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sece_pkg::ST_IDLE: begin
                if (w_take_entry) begin
                    n_state = sece_pkg::ST_EMIT;
                end
            end
            sece_pkg::ST_EMIT: begin
                if (w_chain_done && !w_take_entry) begin
                    n_state = sece_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sece_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        case (r_state)
            sece_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = w_take_entry;
            end
            sece_pkg::ST_EMIT: begin
                o_out_valid   = 1'b1;
                o_in_ready    = w_chain_done;
                o_cmd.load    = w_take_entry;
                o_cmd.advance = i_status.out_ready && !i_status.last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/sece_dp.sv
// datapath: config registers, entry decode and per-tile command registers
// depends on sece_pkg for constants and the entry and command types
module sece_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sece_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sece_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  sece_pkg::t_entry                 i_entry,
    input  sece_pkg::t_dp_cmd                i_cmd,
    output logic [15:0]                      o_tile_code,
    output logic [3:0]                       o_colour_bank_out,
    output logic                             o_flip_x_out,
    output logic                             o_flip_y_out,
    output logic signed [9:0]                o_screen_x,
    output logic signed [10:0]               o_screen_y,
    output logic                             o_last
);

    localparam int PW = sece_pkg::POS_W;

    logic [3:0]                   r_sprite_x_offset;
    logic                         r_screen_flipped;

    logic [15:0]                  r_code;
    logic [3:0]                   r_colour;
    logic                         r_flip_x;
    logic                         r_flip_y;
    logic [sece_pkg::SX_W-1:0]    r_x;
    logic [PW-1:0]                r_y;
    logic [sece_pkg::CHAIN_W-1:0] r_left;

    logic [8:0]                   w_x9, w_y9, w_y_inv;
    logic [PW-1:0]                w_x_wrap, w_x_off, w_x_fin;
    logic [PW-1:0]                w_off, w_y_base, w_y_fin, w_span, w_y_start;
    logic [sece_pkg::CHAIN_W-1:0] w_chain_m1;
    logic                         w_fx, w_fy;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_x_offset <= 4'd0;
            r_screen_flipped  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sece_pkg::CFG_SPRITE_X_OFFSET: r_sprite_x_offset <= i_cfg_data;
                sece_pkg::CFG_SCREEN_FLIPPED:  r_screen_flipped  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // x position: wrap above the limit, add offset, mirror on flipped screen
    assign w_off    = {7'd0, r_sprite_x_offset};
    assign w_x9     = {i_entry.attribute_byte[sece_pkg::ATTR_X_MSB], i_entry.x_low_byte};
    assign w_x_wrap = ({2'd0, w_x9} > sece_pkg::X_WRAP_LIMIT)
                      ? ({2'd0, w_x9} - sece_pkg::POS_WRAP) : {2'd0, w_x9};
    assign w_x_off  = w_x_wrap + w_off;
    assign w_x_fin  = r_screen_flipped ? (sece_pkg::FLIP_X_BASE - w_x_off) : w_x_off;

    // y position: invert modulo 512, lift one tile, on flipped screen mirror and subtract offset
    assign w_y9     = {i_entry.attribute_byte[sece_pkg::ATTR_Y_MSB], i_entry.y_low_byte};
    assign w_y_inv  = sece_pkg::Y_BASE - w_y9;
    assign w_y_base = {2'd0, w_y_inv} - sece_pkg::TILE_STEP;
    assign w_y_fin  = r_screen_flipped ? (sece_pkg::FLIP_Y_BASE - w_y_base - w_off)
                                       : w_y_base;

    // flips and chain start
    assign w_fx       = i_entry.attribute_byte[sece_pkg::ATTR_FLIP_X] ^ r_screen_flipped;
    assign w_fy       = i_entry.attribute_byte[sece_pkg::ATTR_FLIP_Y] ^ r_screen_flipped;
    assign w_chain_m1 = i_entry.attribute_byte[sece_pkg::ATTR_CHAIN_LSB +: sece_pkg::CHAIN_W];
    assign w_span     = {4'd0, w_chain_m1, 4'd0};

    // chain runs downward when flip y is set, upward otherwise
    always_comb begin
        if (w_fy) begin
            w_y_start = r_screen_flipped ? w_y_fin : (w_y_fin - w_span);
        end else begin
            w_y_start = r_screen_flipped ? (w_y_fin + w_span) : w_y_fin;
        end
    end

    // per-tile command registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code   <= {i_entry.code_high_byte, i_entry.code_low_byte};
            r_colour <= i_entry.colour_bank_in;
            r_flip_x <= w_fx;
            r_flip_y <= w_fy;
            r_x      <= w_x_fin[sece_pkg::SX_W-1:0];
            r_y      <= w_y_start;
            r_left   <= w_chain_m1;
        end else if (i_cmd.advance) begin
            r_code <= r_code + 16'd1;
            r_y    <= r_flip_y ? (r_y + sece_pkg::TILE_STEP) : (r_y - sece_pkg::TILE_STEP);
            r_left <= r_left - 3'd1;
        end
    end

    assign o_tile_code       = r_code;
    assign o_colour_bank_out = r_colour;
    assign o_flip_x_out      = r_flip_x;
    assign o_flip_y_out      = r_flip_y;
    assign o_screen_x        = $signed(r_x);
    assign o_screen_y        = $signed(r_y);
    assign o_last            = (r_left == 3'd0);

endmodule

FILE: rtl/sprite_entry_chain_expander.sv
// Sprite entry chain expander, top level: controller plus datapath.
// An entry is decoded in the cycle it is accepted; its first command is valid the next cycle.
// One draw command per cycle while the output is ready. An entry of n tiles (1 to 8) gives n
// commands, and the next entry is taken in the cycle its last command is taken. A disabled
// entry gives no command. Config writes are taken every cycle. Synchronous active-low reset
// clears the state machine and sets the X offset to 0 and the screen to unflipped.
module sprite_entry_chain_expander (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sece_in_if.sink           i_item,
    sece_out_if.source        o_result,
    sece_cfg_if.sink          i_cfg
);

    sece_pkg::t_entry       w_entry;
    sece_pkg::t_dp_cmd      w_cmd;
    sece_pkg::t_ctrl_status w_status;
    logic                   w_last;

    // pack the input word
    assign w_entry.y_low_byte     = i_item.y_low_byte;
    assign w_entry.attribute_byte = i_item.attribute_byte;
    assign w_entry.code_low_byte  = i_item.code_low_byte;
    assign w_entry.code_high_byte = i_item.code_high_byte;
    assign w_entry.colour_bank_in = i_item.colour_bank_in;
    assign w_entry.x_low_byte     = i_item.x_low_byte;

    // status into the controller
    assign w_status.in_valid      = i_item.valid;
    assign w_status.entry_enabled = i_item.attribute_byte[sece_pkg::ATTR_ENABLE];
    assign w_status.out_ready     = o_result.ready;
    assign w_status.last          = w_last;

    // config is always accepted
    assign i_cfg.ready = 1'b1;

    sece_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (w_status),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (w_cmd)
    );

    sece_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_entry           (w_entry),
        .i_cmd             (w_cmd),
        .o_tile_code       (o_result.tile_code),
        .o_colour_bank_out (o_result.colour_bank_out),
        .o_flip_x_out      (o_result.flip_x_out),
        .o_flip_y_out      (o_result.flip_y_out),
        .o_screen_x        (o_result.screen_x),
        .o_screen_y        (o_result.screen_y),
        .o_last            (w_last)
    );

    assign o_result.last_of_chain = w_last;

endmodule

FILE: rtl/sece_checker.sv
// port-level checker for the sprite entry chain expander, bound to the top level
// depends on the top level's channel signals and sprite_entry_chain_expander_assert.svh
`include "sprite_entry_chain_expander_assert.svh"

module sece_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_last,
    input logic [15:0] i_out_code
);

    logic w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // a stalled command stays offered
    `SECE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // a new entry only enters when no chain is pending past this cycle
    `SECE_ASSERT_NOW(a_in_gap, i_clk, i_rst_n, w_in_acc, !i_out_valid || (i_out_last && i_out_ready))

    // within a chain the tile code steps by one
    `SECE_ASSERT_NEXT(a_code_step, i_clk, i_rst_n, w_out_acc && !i_out_last, i_out_valid && (i_out_code == 16'($past(i_out_code) + 16'd1)))

    // nothing is offered right after reset
    `SECE_ASSERT_NEXT_RST(a_rst_quiet, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind sprite_entry_chain_expander sece_checker u_sece_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_last  (o_result.last_of_chain),
    .i_out_code  (o_result.tile_code)
);
